// ===== hdl/rpn_pkg.sv =====
// Shared types, character codes and the microcode table of the postfix evaluator.
package rpn_pkg;

    // Datapath sizes
    localparam int WORD_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int PC_W            = 4;

    // Character codes
    localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;

    // Micro-actions
    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_FETCH = 4'd1;  // latch the incoming character
    localparam logic [3:0] ACT_PUSHD = 4'd2;  // push operand (byte minus '0')
    localparam logic [3:0] ACT_POPR  = 4'd3;  // pop right operand
    localparam logic [3:0] ACT_POPL  = 4'd4;  // capture right, pop left operand
    localparam logic [3:0] ACT_CAPL  = 4'd5;  // capture left operand
    localparam logic [3:0] ACT_DIVST = 4'd6;  // start the divider
    localparam logic [3:0] ACT_EXEC  = 4'd7;  // compute the operator result
    localparam logic [3:0] ACT_PUSHR = 4'd8;  // push the operator result
    localparam logic [3:0] ACT_POPT  = 4'd9;  // pop the final top of stack
    localparam logic [3:0] ACT_EMIT  = 4'd10; // load the output register, clear

    // Hold conditions: the step repeats while its hold is active
    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_INPUT = 2'd1;
    localparam logic [1:0] HOLD_DIV   = 2'd2;
    localparam logic [1:0] HOLD_OUT   = 2'd3;

    // Jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_OPER     = 3'd2;
    localparam logic [2:0] COND_NOT_DIV  = 3'd3;
    localparam logic [2:0] COND_NOT_LAST = 3'd4;

    // Step addresses
    localparam logic [PC_W-1:0] STEP_FETCH = 4'd0;
    localparam logic [PC_W-1:0] STEP_PUSHD = 4'd1;
    localparam logic [PC_W-1:0] STEP_POPR  = 4'd2;
    localparam logic [PC_W-1:0] STEP_POPL  = 4'd3;
    localparam logic [PC_W-1:0] STEP_CAPL  = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIVST = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIVWT = 4'd6;
    localparam logic [PC_W-1:0] STEP_EXEC  = 4'd7;
    localparam logic [PC_W-1:0] STEP_PUSHR = 4'd8;
    localparam logic [PC_W-1:0] STEP_LAST  = 4'd9;
    localparam logic [PC_W-1:0] STEP_POPT  = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT  = 4'd11;

    typedef struct packed {
        logic [3:0]      act;
        logic [1:0]      hold;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Sequencer status inputs
    typedef struct packed {
        logic in_valid;
        logic in_oper;
        logic is_div;
        logic is_last;
        logic div_busy;
        logic out_full;
    } t_seq_stat;

    // Sequencer outputs
    typedef struct packed {
        logic [3:0] act;
        logic       in_ready;
    } t_seq_ctrl;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctrl;

    typedef struct packed {
        logic underflow;
        logic overflow;
    } t_stk_flags;

    typedef struct packed {
        logic start;
        logic exec;
    } t_alu_ctrl;

    function automatic logic is_operator(input logic [SYM_W-1:0] sym);
        return (sym == CH_ADD) || (sym == CH_SUB) || (sym == CH_MUL) || (sym == CH_DIV);
    endfunction

    // Microprogram
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            STEP_FETCH: w = '{ACT_FETCH, HOLD_INPUT, COND_OPER,     STEP_POPR};
            STEP_PUSHD: w = '{ACT_PUSHD, HOLD_NONE,  COND_ALWAYS,   STEP_LAST};
            STEP_POPR:  w = '{ACT_POPR,  HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_POPL:  w = '{ACT_POPL,  HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_CAPL:  w = '{ACT_CAPL,  HOLD_NONE,  COND_NOT_DIV,  STEP_EXEC};
            STEP_DIVST: w = '{ACT_DIVST, HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_DIVWT: w = '{ACT_NONE,  HOLD_DIV,   COND_NEVER,    STEP_FETCH};
            STEP_EXEC:  w = '{ACT_EXEC,  HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_PUSHR: w = '{ACT_PUSHR, HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_LAST:  w = '{ACT_NONE,  HOLD_NONE,  COND_NOT_LAST, STEP_FETCH};
            STEP_POPT:  w = '{ACT_POPT,  HOLD_NONE,  COND_NEVER,    STEP_FETCH};
            STEP_EMIT:  w = '{ACT_EMIT,  HOLD_OUT,   COND_ALWAYS,   STEP_FETCH};
            default:    w = '{ACT_NONE,  HOLD_NONE,  COND_ALWAYS,   STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/rpn_seq.sv =====
// Microcode sequencer: step counter, control ROM, hold and jump logic.
module rpn_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpn_pkg::t_seq_stat  i_stat,
    output rpn_pkg::t_seq_ctrl  o_ctrl
);
    import rpn_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            holding;
    logic            jump;

    assign uw = ucode(r_pc);

    // Hold evaluation
    always_comb begin
        case (uw.hold)
            HOLD_INPUT: holding = !i_stat.in_valid;
            HOLD_DIV:   holding = i_stat.div_busy;
            HOLD_OUT:   holding = i_stat.out_full;
            default:    holding = 1'b0;
        endcase
    end

    // Jump evaluation
    always_comb begin
        case (uw.cond)
            COND_ALWAYS:   jump = 1'b1;
            COND_OPER:     jump = i_stat.in_oper;
            COND_NOT_DIV:  jump = !i_stat.is_div;
            COND_NOT_LAST: jump = !i_stat.is_last;
            default:       jump = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        if (holding) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // No transfer is taken while reset is held
    assign o_ctrl.act      = holding ? ACT_NONE : uw.act;
    assign o_ctrl.in_ready = (uw.hold == HOLD_INPUT) && i_rst_n;

endmodule

// ===== hdl/rpn_stack.sv =====
// Operand stack: memory with registered read, count and sticky underflow/overflow flags.
module rpn_stack #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpn_pkg::t_stk_ctrl          i_ctrl,
    input  logic [rpn_pkg::WORD_W-1:0]  i_push_data,
    output logic [rpn_pkg::WORD_W-1:0]  o_pop_value,
    output rpn_pkg::t_stk_flags         o_flags
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_pop_empty;
    logic [CW-1:0]     r_count;
    logic              r_unf;
    logic              r_ovf;
    logic              is_empty;
    logic              is_full;
    logic [CW-1:0]     top_cnt;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);
    assign top_cnt  = r_count - CW'(1);
    assign wr_addr  = r_count[AW-1:0];
    assign rd_addr  = top_cnt[AW-1:0];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !is_full) begin
            mem[wr_addr] <= i_push_data;
        end
        if (i_ctrl.pop && !is_empty) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Count and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_unf       <= 1'b0;
            r_ovf       <= 1'b0;
            r_pop_empty <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
            r_unf   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_ctrl.push) begin
            if (is_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end else if (i_ctrl.pop) begin
            r_pop_empty <= is_empty;
            if (is_empty) begin
                r_unf <= 1'b1;
            end else begin
                r_count <= top_cnt;
            end
        end
    end

    // Empty pop reads as all ones
    assign o_pop_value       = r_pop_empty ? '1 : r_rd_data;
    assign o_flags.underflow = r_unf;
    assign o_flags.overflow  = r_ovf;

endmodule

// ===== hdl/rpn_alu.sv =====
// Operator unit: add, subtract, multiply and a radix-2 restoring divider.
module rpn_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpn_pkg::t_alu_ctrl          i_ctrl,
    input  logic [rpn_pkg::SYM_W-1:0]   i_symbol,
    input  logic [rpn_pkg::WORD_W-1:0]  i_left,
    input  logic [rpn_pkg::WORD_W-1:0]  i_right,
    output logic [rpn_pkg::WORD_W-1:0]  o_result,
    output logic                        o_busy
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(WORD_W - 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic              r_neg;
    logic [WORD_W-1:0] r_res;
    logic [WORD_W-1:0] n_res;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              fits;
    logic [WORD_W-1:0] abs_l;
    logic [WORD_W-1:0] abs_r;
    logic [WORD_W-1:0] mul_lo;

    assign abs_l   = i_left[WORD_W-1]  ? (~i_left + WORD_W'(1))  : i_left;
    assign abs_r   = i_right[WORD_W-1] ? (~i_right + WORD_W'(1)) : i_right;
    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});
    assign mul_lo  = i_left * i_right;

    // Divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == LAST_ITER) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Divider datapath: one quotient bit per cycle on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_quo <= abs_l;
            r_dvs <= abs_r;
            r_neg <= i_left[WORD_W-1] ^ i_right[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], fits};
        end
    end

    // Result selection
    always_comb begin
        case (i_symbol)
            CH_ADD:  n_res = i_left + i_right;
            CH_SUB:  n_res = i_left - i_right;
            CH_MUL:  n_res = mul_lo;
            CH_DIV: begin
                if (i_right == '0) begin
                    n_res = '0;
                end else begin
                    n_res = r_neg ? (~r_quo + WORD_W'(1)) : r_quo;
                end
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;
    assign o_busy   = r_busy;

endmodule

// ===== hdl/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator: sequencer, stack, operator unit, output register.
//
// Takes one character of a postfix expression per transfer. + - * / pop two
// operands (right first) and push the 32-bit wrapped result; any other byte
// pushes the byte minus '0'. On a character flagged last the top is popped
// and delivered with sticky underflow, overflow and divide-by-zero flags,
// after which the stack and flags clear. Empty pops give -1, pushes onto a
// full stack are dropped, division by zero gives 0. One character is worked
// at a time by a microcoded sequencer, and / waits on the radix-2 divider,
// which produces one quotient bit per cycle. A last character adds a pop and
// the output load, plus any wait for the output register to be taken. The
// next character transfers as soon as the sequencer returns to its fetch
// step, even while a result still waits.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [rpn_pkg::SYM_W-1:0]          i_symbol,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rpn_pkg::WORD_W-1:0]  o_value,
    output logic                               o_underflow_seen,
    output logic                               o_overflow_seen,
    output logic                               o_divide_by_zero_seen
);
    import rpn_pkg::*;

    t_seq_stat         seq_stat;
    t_seq_ctrl         seq_ctrl;
    t_stk_ctrl         stk_ctrl;
    t_stk_flags        stk_flags;
    t_alu_ctrl         alu_ctrl;
    logic [3:0]        act;
    logic [WORD_W-1:0] pop_value;
    logic [WORD_W-1:0] push_data;
    logic [WORD_W-1:0] alu_res;
    logic              div_busy;

    logic [SYM_W-1:0]  r_symbol;
    logic              r_last;
    logic [WORD_W-1:0] r_left;
    logic [WORD_W-1:0] r_right;
    logic              r_dz;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_value;
    logic              r_out_unf;
    logic              r_out_ovf;
    logic              r_out_dz;

    assign act = seq_ctrl.act;

    // Sequencer
    assign seq_stat.in_valid = i_valid;
    assign seq_stat.in_oper  = is_operator(i_symbol);
    assign seq_stat.is_div   = (r_symbol == CH_DIV);
    assign seq_stat.is_last  = r_last;
    assign seq_stat.div_busy = div_busy;
    assign seq_stat.out_full = r_out_valid && !i_ready;

    rpn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_ctrl  (seq_ctrl)
    );

    // Stack
    assign stk_ctrl.push  = (act == ACT_PUSHD) || (act == ACT_PUSHR);
    assign stk_ctrl.pop   = (act == ACT_POPR) || (act == ACT_POPL) || (act == ACT_POPT);
    assign stk_ctrl.clear = (act == ACT_EMIT);
    assign push_data = (act == ACT_PUSHD) ? ({{(WORD_W - SYM_W){1'b0}}, r_symbol}
                                             - WORD_W'(CH_ZERO))
                                          : alu_res;

    rpn_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (stk_ctrl),
        .i_push_data (push_data),
        .o_pop_value (pop_value),
        .o_flags     (stk_flags)
    );

    // Operator unit
    assign alu_ctrl.start = (act == ACT_DIVST);
    assign alu_ctrl.exec  = (act == ACT_EXEC);

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (alu_ctrl),
        .i_symbol (r_symbol),
        .i_left   (r_left),
        .i_right  (r_right),
        .o_result (alu_res),
        .o_busy   (div_busy)
    );

    // Character latch and operand capture
    always_ff @(posedge i_clk) begin
        if (act == ACT_FETCH) begin
            r_symbol <= i_symbol;
            r_last   <= i_last;
        end
        if (act == ACT_POPL) begin
            r_right <= pop_value;
        end
        if (act == ACT_CAPL) begin
            r_left <= pop_value;
        end
    end

    // Sticky divide-by-zero flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= 1'b0;
        end else if (act == ACT_EMIT) begin
            r_dz <= 1'b0;
        end else if ((act == ACT_EXEC) && (r_symbol == CH_DIV) && (r_right == '0)) begin
            r_dz <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (act == ACT_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act == ACT_EMIT) begin
            r_value   <= pop_value;
            r_out_unf <= stk_flags.underflow;
            r_out_ovf <= stk_flags.overflow;
            r_out_dz  <= r_dz;
        end
    end

    assign o_ready               = seq_ctrl.in_ready;
    assign o_valid               = r_out_valid;
    assign o_value               = r_value;
    assign o_underflow_seen      = r_out_unf;
    assign o_overflow_seen       = r_out_ovf;
    assign o_divide_by_zero_seen = r_out_dz;

endmodule
